FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk; ASSERT_CLK checks are disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising edge of clk, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// widths, register map, reset values and shared types of the pulse scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int unsigned CNT_W        = 16;
  localparam int unsigned LED_W        = 4;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned CFG_IDX_W    = 3;

  typedef logic [CNT_W-1:0] cnt_t;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_BAR_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_CH0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_CH1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_CH2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_CH3 = 3'd6;

  // register reset values
  localparam cnt_t BAR_LEN_RST      = 16'd2931;
  localparam cnt_t ON_TIME_RST      = 16'd97;
  localparam cnt_t HOLD_TICKS_RST   = 16'd488;
  localparam cnt_t INTERVAL_CH0_RST = 16'd977;
  localparam cnt_t INTERVAL_CH1_RST = 16'd733;
  localparam cnt_t INTERVAL_CH2_RST = 16'd586;
  localparam cnt_t INTERVAL_CH3_RST = 16'd419;

  // per-tick control shared by all channels
  typedef struct packed {
    logic advance;   // tick leaves the input register this cycle
    logic run;       // running after this tick's button logic
    logic restart;   // tick resumes from pause
    logic bar_end;   // bar counter reached the end of the bar
  } tick_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/pps_if.sv
// ----------------------------------------------------------------------------
// pulse scheduler stream interfaces
// tick channel in, result channel out, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_tick_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface pps_result_if;
  import pps_pkg::*;

  logic             valid;
  logic             ready;
  logic [LED_W-1:0] led_pattern;
  logic             running;

  modport source (output valid, output led_pattern, output running, input ready);
  modport sink   (input valid, input led_pattern, input running, output ready);
endinterface

`default_nettype wire

FILE: hdl/pps_channel.sv
// ----------------------------------------------------------------------------
// pps_channel
// one pulse channel: start point, dark point and lit flag with their update
// ----------------------------------------------------------------------------
`default_nettype none

module pps_channel (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::tick_ctrl_t ctrl,
  input  pps_pkg::cnt_t      bar_step,
  input  pps_pkg::cnt_t      on_time,
  input  pps_pkg::cnt_t      interval,
  output logic               lit_next
);
  import pps_pkg::*;

  cnt_t next_start;
  cnt_t dark_at;
  logic lit;

  cnt_t next_start_next;
  cnt_t dark_at_next;

  cnt_t ns_base;
  cnt_t da_base;
  logic lit_base;
  logic light;
  cnt_t da_lit;
  logic lit_on;
  logic darken;
  cnt_t ns_adv;

  always_comb begin
    // a resume starts from a cleared channel
    ns_base  = ctrl.restart ? '0 : next_start;
    da_base  = ctrl.restart ? '0 : dark_at;
    lit_base = ctrl.restart ? 1'b0 : lit;

    light  = (bar_step >= ns_base) && !lit_base;
    da_lit = light ? cnt_t'(ns_base + on_time) : da_base;
    lit_on = lit_base || light;
    darken = lit_on && (bar_step >= da_lit);
    ns_adv = darken ? cnt_t'(ns_base + interval) : ns_base;

    if (!ctrl.run) begin
      lit_next        = 1'b0;
      next_start_next = next_start;
      dark_at_next    = dark_at;
    end else if (ctrl.bar_end) begin
      lit_next        = 1'b0;
      next_start_next = '0;
      dark_at_next    = '0;
    end else begin
      lit_next        = lit_on && !darken;
      next_start_next = ns_adv;
      dark_at_next    = da_lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_start <= '0;
      dark_at    <= '0;
      lit        <= 1'b0;
    end else if (ctrl.advance) begin
      next_start <= next_start_next;
      dark_at    <= dark_at_next;
      lit        <= lit_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/polyrhythm_pulse_scheduler.sv
// ----------------------------------------------------------------------------
// polyrhythm pulse scheduler
// bar counter with per-channel pulse trains and a hold-to-toggle run button
// ----------------------------------------------------------------------------
//  port     dir  handshake    payload
//  tick     in   valid/ready  button_level
//  result   out  valid/ready  led_pattern, running
//  cfg      in   cfg_we       cfg_index, cfg_data
//
// one tick accepted per cycle while results are taken; a result passes
// through the input register and then the result register
// while the sink holds a result back the input register keeps one further
// tick, then tick.ready falls until the result is taken
// rst restores the register defaults, running state and a cleared bar
`default_nettype none

`include "assert_macros.svh"

module polyrhythm_pulse_scheduler #(
  parameter int unsigned CHANNELS = pps_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  pps_tick_if.sink                     tick,
  pps_result_if.source                 result,
  input  logic                         cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pps_pkg::CNT_W-1:0]    cfg_data
);
  import pps_pkg::*;

  // configuration
  cnt_t bar_len;
  cnt_t on_time;
  cnt_t hold_ticks;
  cnt_t interval [MAX_CHANNELS];

  // pipeline
  logic             s1_valid;
  logic             s1_button;
  logic             res_valid;
  logic [LED_W-1:0] res_led;
  logic             res_running;
  logic             adv;

  // tick state
  logic button_held;
  cnt_t hold_count;
  logic run_flag;
  cnt_t bar_count;

  cnt_t hold_count_next;
  logic run_flag_next;
  cnt_t bar_count_next;
  cnt_t hold_inc;
  logic toggle;
  cnt_t bar_step;

  tick_ctrl_t            ctrl;
  logic [CHANNELS-1:0]   chan_lit;
  logic [LED_W-1:0]      led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_len      <= BAR_LEN_RST;
      on_time      <= ON_TIME_RST;
      hold_ticks   <= HOLD_TICKS_RST;
      interval[0]  <= INTERVAL_CH0_RST;
      interval[1]  <= INTERVAL_CH1_RST;
      interval[2]  <= INTERVAL_CH2_RST;
      interval[3]  <= INTERVAL_CH3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BAR_LEN:      bar_len     <= cfg_data;
        REG_ON_TIME:      on_time     <= cfg_data;
        REG_HOLD_TICKS:   hold_ticks  <= cfg_data;
        REG_INTERVAL_CH0: interval[0] <= cfg_data;
        REG_INTERVAL_CH1: interval[1] <= cfg_data;
        REG_INTERVAL_CH2: interval[2] <= cfg_data;
        REG_INTERVAL_CH3: interval[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv        = s1_valid && (!res_valid || result.ready);
  assign tick.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
    if (tick.valid && tick.ready) begin
      s1_button <= tick.button_level;
    end
  end

  // button, run/pause and bar counter
  always_comb begin
    hold_inc        = button_held ? cnt_t'(hold_count + 1'b1) : '0;
    toggle          = s1_button && (hold_inc >= hold_ticks);
    hold_count_next = (s1_button && !toggle) ? hold_inc : '0;
    run_flag_next   = run_flag ^ toggle;

    ctrl.advance = adv;
    ctrl.run     = run_flag_next;
    ctrl.restart = toggle && !run_flag;
    bar_step     = ctrl.restart ? '0 : cnt_t'(bar_count + 1'b1);
    ctrl.bar_end = bar_step >= bar_len;

    if (!run_flag_next) begin
      bar_count_next = bar_count;
    end else if (ctrl.bar_end) begin
      bar_count_next = '0;
    end else begin
      bar_count_next = bar_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_held <= 1'b0;
      hold_count  <= '0;
      run_flag    <= 1'b1;
      bar_count   <= '0;
    end else if (adv) begin
      button_held <= s1_button;
      hold_count  <= hold_count_next;
      run_flag    <= run_flag_next;
      bar_count   <= bar_count_next;
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    pps_channel u_chan (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .bar_step (bar_step),
      .on_time  (on_time),
      .interval (interval[i]),
      .lit_next (chan_lit[i])
    );
  end

  assign led_next = LED_W'(chan_lit);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (adv) begin
      res_led     <= led_next;
      res_running <= run_flag_next;
    end
  end

  assign result.valid       = res_valid;
  assign result.led_pattern = res_led;
  assign result.running     = res_running;

  `ASSERT_CLK(a_hold_idle, !button_held |-> hold_count == '0, "hold count set while button released")
  `ASSERT_CLK(a_pause_stable, adv && !run_flag && !toggle |=> $stable(bar_count), "bar moved while paused")
  `ASSERT_CLK(a_pause_dark, res_valid && !res_running |-> res_led == '0, "leds lit while paused")
  `ASSERT_CLK(a_unused_dark, res_valid |-> (res_led >> CHANNELS) == '0, "unused channel lit")

endmodule

`default_nettype wire
